// File: sv/vspc_pkg.sv
// Package for the version string parse and compare block.
// Types, parse phases, error codes, character codes and register indexes.
// No dependencies.
package vspc_pkg;

    localparam int PART_W = 16;
    localparam int ACC_W  = 20;

    typedef logic [2:0] t_phase;
    typedef logic [2:0] t_err;
    typedef logic [7:0] t_char;
    typedef logic [PART_W-1:0] t_part;

    localparam t_phase PH_LEAD       = 3'd0;
    localparam t_phase PH_AFTER_V    = 3'd1;
    localparam t_phase PH_NEED_DIGIT = 3'd2;
    localparam t_phase PH_DIGITS     = 3'd3;
    localparam t_phase PH_TRAIL      = 3'd4;

    localparam t_err ERR_NONE     = 3'd0;
    localparam t_err ERR_DIGIT    = 3'd1;
    localparam t_err ERR_OVERFLOW = 3'd2;
    localparam t_err ERR_DOT      = 3'd3;
    localparam t_err ERR_TRAILING = 3'd4;

    localparam t_char CH_NUL   = 8'h00;
    localparam t_char CH_TAB   = 8'h09;
    localparam t_char CH_LF    = 8'h0A;
    localparam t_char CH_CR    = 8'h0D;
    localparam t_char CH_SPACE = 8'h20;
    localparam t_char CH_DOT   = 8'h2E;
    localparam t_char CH_ZERO  = 8'h30;
    localparam t_char CH_NINE  = 8'h39;
    localparam t_char CH_UPPER_V = 8'h56;
    localparam t_char CH_LOWER_V = 8'h76;

    localparam logic [ACC_W-1:0] PART_MAX = 20'd65535;

    localparam logic [2:0] REG_RUN_MAJOR = 3'd0;
    localparam logic [2:0] REG_RUN_MINOR = 3'd1;
    localparam logic [2:0] REG_RUN_PATCH = 3'd2;
    localparam logic [2:0] REG_EXP_MAJOR = 3'd3;
    localparam logic [2:0] REG_EXP_MINOR = 3'd4;
    localparam logic [2:0] REG_EXP_PATCH = 3'd5;
    localparam logic [2:0] REG_TRIM      = 3'd6;

    localparam int OUT_DATA_W = 56;

    typedef struct packed {
        logic  valid_res;
        t_err  error_code;
        t_part major;
        t_part minor;
        t_part patch;
    } t_parse_res;

    typedef struct packed {
        t_part run_major;
        t_part run_minor;
        t_part run_patch;
        t_part exp_major;
        t_part exp_minor;
        t_part exp_patch;
        logic  trim;
    } t_cfg;

    function automatic logic is_trim_char(input t_char c);
        return (c == CH_LF) || (c == CH_CR) || (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    // error raised when the string ends in the given phase
    function automatic t_err end_error(input t_phase ph, input logic [1:0] idx);
        t_err e;
        e = ERR_NONE;
        case (ph)
            PH_DIGITS: begin
                if (idx < 2'd2) e = ERR_DOT;
            end
            PH_TRAIL: e = ERR_NONE;
            default: e = ERR_DIGIT;
        endcase
        return e;
    endfunction

endpackage

// File: sv/vspc_parse.sv
// Character parser: per-character state update and end-of-string evaluation.
// Holds the parse state and a one-entry register for the finished result.
// Depends on vspc_pkg.
module vspc_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  vspc_pkg::t_char      i_char,
    input  logic                 i_last,
    input  logic                 i_trim,
    input  logic                 i_res_take,
    output logic                 o_consume,
    output logic                 o_res_valid,
    output vspc_pkg::t_parse_res o_res
);
    import vspc_pkg::*;

    t_phase          r_phase;
    logic [1:0]      r_idx;
    t_part           r_acc;
    t_part           r_first;
    t_part           r_second;
    t_err            r_err;
    logic            r_ended;
    logic            r_res_valid;
    t_parse_res      r_res;

    t_phase          n_phase;
    logic [1:0]      n_idx;
    t_part           n_acc;
    t_part           n_first;
    t_part           n_second;
    t_err            n_err;
    logic            n_ended;
    t_parse_res      n_res;

    logic            digit;
    logic [ACC_W-1:0] acc_ext;
    logic [ACC_W-1:0] acc_next;
    logic            res_free;

    assign digit    = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign acc_ext  = {{(ACC_W-PART_W){1'b0}}, r_acc};
    assign acc_next = (acc_ext << 3) + (acc_ext << 1)
                    + {{(ACC_W-8){1'b0}}, i_char - CH_ZERO};

    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_acc    = r_acc;
        n_first  = r_first;
        n_second = r_second;
        n_err    = r_err;
        n_ended  = r_ended;

        if (!r_ended && r_err == ERR_NONE) begin
            if (i_char == CH_NUL) begin
                n_ended = 1'b1;
                n_err   = end_error(r_phase, r_idx);
            end else begin
                case (r_phase)
                    PH_LEAD, PH_AFTER_V, PH_NEED_DIGIT: begin
                        if (r_phase == PH_LEAD && i_char == CH_SPACE) begin
                            n_phase = PH_LEAD;
                        end else if (r_phase == PH_LEAD &&
                                     (i_char == CH_LOWER_V || i_char == CH_UPPER_V)) begin
                            n_phase = PH_AFTER_V;
                        end else if (digit) begin
                            if (acc_next > PART_MAX) begin
                                n_err = ERR_OVERFLOW;
                            end else begin
                                n_acc   = acc_next[PART_W-1:0];
                                n_phase = PH_DIGITS;
                            end
                        end else begin
                            n_err = ERR_DIGIT;
                        end
                    end
                    PH_DIGITS: begin
                        if (digit) begin
                            if (acc_next > PART_MAX) begin
                                n_err = ERR_OVERFLOW;
                            end else begin
                                n_acc = acc_next[PART_W-1:0];
                            end
                        end else if (i_char == CH_DOT && r_idx < 2'd2) begin
                            if (r_idx == 2'd0) n_first = r_acc;
                            else n_second = r_acc;
                            n_idx   = r_idx + 2'd1;
                            n_acc   = '0;
                            n_phase = PH_NEED_DIGIT;
                        end else if (r_idx < 2'd2) begin
                            n_err = ERR_DOT;
                        end else if (i_trim && is_trim_char(i_char)) begin
                            n_phase = PH_TRAIL;
                        end else begin
                            n_err = ERR_TRAILING;
                        end
                    end
                    PH_TRAIL: begin
                        if (!is_trim_char(i_char)) n_err = ERR_TRAILING;
                    end
                    default: n_err = ERR_TRAILING;
                endcase
            end
        end

        // final character: close the string after it
        if (i_last && !n_ended && n_err == ERR_NONE) begin
            n_err = end_error(n_phase, n_idx);
        end

        n_res.valid_res  = (n_err == ERR_NONE);
        n_res.error_code = n_err;
        n_res.major      = n_res.valid_res ? n_first  : '0;
        n_res.minor      = n_res.valid_res ? n_second : '0;
        n_res.patch      = n_res.valid_res ? n_acc    : '0;
    end

    assign res_free  = !r_res_valid || i_res_take;
    assign o_consume = i_in_valid && (!i_last || res_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LEAD;
            r_idx    <= '0;
            r_acc    <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_err    <= ERR_NONE;
            r_ended  <= 1'b0;
        end else if (o_consume) begin
            if (i_last) begin
                r_phase  <= PH_LEAD;
                r_idx    <= '0;
                r_acc    <= '0;
                r_first  <= '0;
                r_second <= '0;
                r_err    <= ERR_NONE;
                r_ended  <= 1'b0;
            end else begin
                r_phase  <= n_phase;
                r_idx    <= n_idx;
                r_acc    <= n_acc;
                r_first  <= n_first;
                r_second <= n_second;
                r_err    <= n_err;
                r_ended  <= n_ended;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (o_consume && i_last) begin
            r_res_valid <= 1'b1;
        end else if (i_res_take) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_consume && i_last) r_res <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// File: sv/vspc_compare.sv
// Compare stage: checks the parsed version against the running and expected
// versions and holds the result request in the output register.
// Depends on vspc_pkg.
module vspc_compare (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_res_valid,
    input  vspc_pkg::t_parse_res         i_res,
    input  vspc_pkg::t_cfg               i_cfg,
    output logic                         o_res_take,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [vspc_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import vspc_pkg::*;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] n_out_data;
    logic                  newer;
    logic                  same;

    always_comb begin
        if (i_res.major != i_cfg.run_major) begin
            newer = i_res.major > i_cfg.run_major;
        end else if (i_res.minor != i_cfg.run_minor) begin
            newer = i_res.minor > i_cfg.run_minor;
        end else begin
            newer = i_res.patch > i_cfg.run_patch;
        end
        same = (i_res.major == i_cfg.exp_major) && (i_res.minor == i_cfg.exp_minor)
            && (i_res.patch == i_cfg.exp_patch);
        n_out_data = {2'b00, i_res.error_code, i_res.valid_res && same,
                      i_res.valid_res && newer, i_res.patch, i_res.minor,
                      i_res.major, i_res.valid_res};
    end

    assign o_res_take = i_res_valid && (!r_out_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_take) r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// File: sv/version_string_parse_compare.sv
// Top level of the version string parse and compare block.
// Input register, configuration registers, parser and compare stages.
// Depends on vspc_pkg, vspc_parse and vspc_compare.
//
// The block takes a version string one character per request and, on the
// character marked by tlast, returns one result request: valid flag, the
// three parts, newer-than-running and same-as-expected flags and an error
// code. One character is taken every clock cycle unless the input stalls;
// the rate is set by the parser's per-character update (multiply by ten,
// add, range check), which is combinational. The final character goes
// via the input, parser result and output registers. While one result
// waits at the output, the next string can complete behind it; only a
// third final character stalls the input until the output side takes one.
module version_string_parse_compare (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_code
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] valid_res, [16:1] major, [32:17] minor, [48:33] patch,
    // [49] is_newer, [50] is_same, [53:51] error_code, [55:54] zero
    output logic [55:0] o_m_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import vspc_pkg::*;

    logic       r_in_valid;
    t_char      r_in_char;
    logic       r_in_last;
    t_cfg       r_cfg;

    logic       consume;
    logic       res_valid;
    logic       res_take;
    t_parse_res res;

    assign o_s_tready  = !r_in_valid || consume;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.run_major <= '0;
            r_cfg.run_minor <= '0;
            r_cfg.run_patch <= '0;
            r_cfg.exp_major <= '0;
            r_cfg.exp_minor <= '0;
            r_cfg.exp_patch <= '0;
            r_cfg.trim      <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_RUN_MAJOR: r_cfg.run_major <= i_cfg_data;
                REG_RUN_MINOR: r_cfg.run_minor <= i_cfg_data;
                REG_RUN_PATCH: r_cfg.run_patch <= i_cfg_data;
                REG_EXP_MAJOR: r_cfg.exp_major <= i_cfg_data;
                REG_EXP_MINOR: r_cfg.exp_minor <= i_cfg_data;
                REG_EXP_PATCH: r_cfg.exp_patch <= i_cfg_data;
                REG_TRIM:      r_cfg.trim      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    vspc_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (r_in_valid),
        .i_char      (r_in_char),
        .i_last      (r_in_last),
        .i_trim      (r_cfg.trim),
        .i_res_take  (res_take),
        .o_consume   (consume),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    vspc_compare u_compare (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_cfg       (r_cfg),
        .o_res_take  (res_take),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

// File: sv/vspc_checker.sv
// Port-level assertions for the version string parse and compare block.
// Bound to the top level; sees its ports only.
// Depends on vspc_pkg and version_string_parse_compare.
module vspc_assert (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [55:0] o_m_tdata
);
    import vspc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output request changed while stalled");

    a_no_out_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_m_tvalid)
        else $error("output request straight after reset");

    a_valid_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[0] == (o_m_tdata[53:51] == ERR_NONE)))
        else $error("valid flag disagrees with error code");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> o_m_tdata[50:1] == 50'd0)
        else $error("invalid result carries parts or flags");

    a_error_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[53:51] <= ERR_TRAILING && o_m_tdata[55:54] == 2'd0)
        else $error("error code out of range");

endmodule

bind version_string_parse_compare vspc_assert u_vspc_assert (.*);

// File: verif/vspc_checker.sv
`timescale 1ns / 100ps
// Checker for version_string_parse_compare: tracks register writes, predicts the
// result of every string from its characters and compares each result request.
// Depends on vspc_pkg.
module vspc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_code
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // [0] valid_res, [16:1] major, [32:17] minor, [48:33] patch,
    // [49] is_newer, [50] is_same, [53:51] error_code, [55:54] zero
    input  logic [55:0] i_m_tdata,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_well_formed
);
    import vspc_pkg::*;

    typedef struct packed {
        logic  valid_res;
        t_part major;
        t_part minor;
        t_part patch;
        logic  is_newer;
        logic  is_same;
        t_err  error_code;
    } t_version_res;

    t_part  run_maj, run_min, run_pat;
    t_part  exp_maj, exp_min, exp_pat;
    logic   trim_on;

    t_phase     ph;
    logic [1:0] part_idx;
    int         acc;
    t_part      first_p, second_p;
    t_err       err;
    logic       ended;

    t_version_res versions_due[$];

    function automatic logic is_blank(input t_char c);
        return (c == CH_LF) || (c == CH_CR) || (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    task automatic clear_parse();
        ph       = PH_LEAD;
        part_idx = 2'd0;
        acc      = 0;
        first_p  = '0;
        second_p = '0;
        err      = ERR_NONE;
        ended    = 1'b0;
    endtask

    // end of string: only the first end counts, and never over an earlier error
    task automatic close_string();
        if (!ended && err == ERR_NONE) begin
            if (ph == PH_DIGITS) begin
                if (part_idx < 2'd2) err = ERR_DOT;
            end else if (ph != PH_TRAIL) begin
                err = ERR_DIGIT;
            end
        end
        ended = 1'b1;
    endtask

    task automatic take_digit(input int d);
        int v;
        v = acc * 10 + d;
        if (v > 65535) begin
            err = ERR_OVERFLOW;
        end else begin
            acc = v;
            ph  = PH_DIGITS;
        end
    endtask

    task automatic take_char(input t_char c);
        logic dig;
        dig = (c >= CH_ZERO) && (c <= CH_NINE);
        case (ph)
            PH_LEAD, PH_AFTER_V, PH_NEED_DIGIT: begin
                if (ph == PH_LEAD && (c == CH_LOWER_V || c == CH_UPPER_V)) begin
                    ph = PH_AFTER_V;
                end else if (dig) begin
                    take_digit(c - CH_ZERO);
                end else if (!(ph == PH_LEAD && c == CH_SPACE)) begin
                    err = ERR_DIGIT;
                end
            end
            PH_DIGITS: begin
                if (dig) begin
                    take_digit(c - CH_ZERO);
                end else if (c == CH_DOT && part_idx < 2'd2) begin
                    if (part_idx == 2'd0) first_p = t_part'(acc);
                    else second_p = t_part'(acc);
                    part_idx = part_idx + 2'd1;
                    acc      = 0;
                    ph       = PH_NEED_DIGIT;
                end else if (part_idx < 2'd2) begin
                    err = ERR_DOT;
                end else if (trim_on && is_blank(c)) begin
                    ph = PH_TRAIL;
                end else begin
                    err = ERR_TRAILING;
                end
            end
            PH_TRAIL: begin
                if (!is_blank(c)) err = ERR_TRAILING;
            end
            default: err = ERR_TRAILING;
        endcase
    endtask

    task automatic accept_char(input t_char c, input logic last);
        t_version_res r;
        logic         ok;
        logic         newer;
        t_part        a, b, p;
        if (!ended && err == ERR_NONE) begin
            if (c == CH_NUL) close_string();
            else take_char(c);
        end
        if (last) begin
            close_string();
            ok = (err == ERR_NONE);
            a  = ok ? first_p : '0;
            b  = ok ? second_p : '0;
            p  = ok ? t_part'(acc) : '0;
            if (a != run_maj) newer = (a > run_maj);
            else if (b != run_min) newer = (b > run_min);
            else newer = (p > run_pat);
            r.valid_res  = ok;
            r.major      = a;
            r.minor      = b;
            r.patch      = p;
            r.is_newer   = ok && newer;
            r.is_same    = ok && a == exp_maj && b == exp_min && p == exp_pat;
            r.error_code = err;
            versions_due.push_back(r);
            clear_parse();
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
        case (idx)
            REG_RUN_MAJOR: run_maj = v;
            REG_RUN_MINOR: run_min = v;
            REG_RUN_PATCH: run_pat = v;
            REG_EXP_MAJOR: exp_maj = v;
            REG_EXP_MINOR: exp_min = v;
            REG_EXP_PATCH: exp_pat = v;
            REG_TRIM:      trim_on = v[0];
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    task automatic check_result(input logic [55:0] d);
        t_version_res w;
        if (versions_due.size() == 0) begin
            report_mismatch("result request with no string ended", 1, 0);
            return;
        end
        w = versions_due.pop_front();
        if (d[0] != w.valid_res) report_mismatch("valid_res", d[0], w.valid_res);
        if (d[16:1] != w.major) report_mismatch("major", d[16:1], w.major);
        if (d[32:17] != w.minor) report_mismatch("minor", d[32:17], w.minor);
        if (d[48:33] != w.patch) report_mismatch("patch", d[48:33], w.patch);
        if (d[49] != w.is_newer) report_mismatch("is_newer", d[49], w.is_newer);
        if (d[50] != w.is_same) report_mismatch("is_same", d[50], w.is_same);
        if (d[53:51] != w.error_code) report_mismatch("error_code", d[53:51], w.error_code);
        if (d[55:54] != 2'b00) report_mismatch("pad bits", d[55:54], 0);
        o_checked++;
        if (w.valid_res) o_well_formed++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            run_maj = '0;
            run_min = '0;
            run_pat = '0;
            exp_maj = '0;
            exp_min = '0;
            exp_pat = '0;
            trim_on = 1'b1;
            clear_parse();
            versions_due.delete();
            o_fail_count  = 0;
            o_checked     = 0;
            o_well_formed = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) write_reg(i_cfg_index, i_cfg_data);
            if (i_s_tvalid && i_s_tready) accept_char(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) check_result(i_m_tdata);
        end
        o_pending = versions_due.size();
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Top of the version_string_parse_compare testbench: clock, reset, character
// and register stimulus, output back-pressure and the verdict.
// Depends on vspc_pkg, vspc_checker and the block itself.
module tb_top;
    import vspc_pkg::*;

    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         RANDOM_CHARS = 340;
    localparam logic [2:0] REG_SPARE    = 3'd7;   // beyond the register list

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid, s_tready, s_tlast;
    t_char       s_tdata;
    logic        m_tvalid, m_tready;
    logic [55:0] m_tdata;
    logic        cfg_valid, cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    int    fails, pending, checked, well_formed;
    logic  no_gaps;
    int    stall_reqs, stall_done, hold_cnt;
    int    cycles = 0;
    int    chars_sent, strings_sent, settings_used;
    int    run_v[3], exp_v[3];
    t_char str_buf[$];

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    version_string_parse_compare uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    vspc_checker u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tlast     (s_tlast),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fails),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_well_formed (well_formed)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results outstanding", cycles, pending);
            $display("version_string_parse_compare regression: fail");
            $finish;
        end
    end

    // result side: random gaps, or a long hold-off when one is requested
    initial begin
        m_tready   = 1'b0;
        stall_done = 0;
        hold_cnt   = 0;
        forever begin
            @(negedge clk);
            if (stall_done != stall_reqs) begin
                m_tready = 1'b0;
                hold_cnt = hold_cnt + 1;
                if (hold_cnt >= HOLD_CYCLES) begin
                    hold_cnt   = 0;
                    stall_done = stall_done + 1;
                end
            end else begin
                m_tready = no_gaps || ($urandom_range(99) >= 31);
            end
        end
    end

    function automatic t_char any_blank();
        case ($urandom_range(3))
            0: return CH_LF;
            1: return CH_CR;
            2: return CH_SPACE;
            default: return CH_TAB;
        endcase
    endfunction

    function automatic int pick_part(input int k);
        int r, v;
        r = $urandom_range(99);
        if (r < 25) begin
            v = run_v[k] + int'($urandom_range(2)) - 1;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
        end else if (r < 45) begin
            v = exp_v[k];
        end else if (r < 65) begin
            v = $urandom_range(9);
        end else if (r < 85) begin
            v = $urandom_range(65535);
        end else if (r < 93) begin
            v = 65535;
        end else begin
            v = $urandom_range(99999, 65536);
        end
        return v;
    endfunction

    function automatic logic [15:0] any_reg_value();
        return ($urandom_range(99) < 60) ? 16'($urandom_range(20)) : 16'($urandom_range(65535));
    endfunction

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) str_buf.push_back(t_char'(s[i]));
    endtask

    // valid stays high from one character to the next unless a gap is drawn
    task automatic push_char(input t_char c, input logic last);
        while (!no_gaps && $urandom_range(99) < 31) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = c;
        s_tlast  = last;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        chars_sent++;
    endtask

    task automatic send_buf();
        int n;
        n = str_buf.size();
        for (int i = 0; i < n; i++) push_char(str_buf[i], i == n - 1);
        str_buf.delete();
        strings_sent++;
    endtask

    task automatic send_text(input string s);
        put_text(s);
        send_buf();
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        wait (pending == 0);
        @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        case (idx)
            REG_RUN_MAJOR: run_v[0] = v;
            REG_RUN_MINOR: run_v[1] = v;
            REG_RUN_PATCH: run_v[2] = v;
            REG_EXP_MAJOR: exp_v[0] = v;
            REG_EXP_MINOR: exp_v[1] = v;
            REG_EXP_PATCH: exp_v[2] = v;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] rma, input logic [15:0] rmi,
                              input logic [15:0] rpa, input logic [15:0] ema,
                              input logic [15:0] emi, input logic [15:0] epa,
                              input logic [15:0] trim_word);
        drain();
        write_reg(REG_RUN_MAJOR, rma);
        write_reg(REG_RUN_MINOR, rmi);
        write_reg(REG_RUN_PATCH, rpa);
        write_reg(REG_EXP_MAJOR, ema);
        write_reg(REG_EXP_MINOR, emi);
        write_reg(REG_EXP_PATCH, epa);
        write_reg(REG_TRIM, trim_word);
        write_reg(REG_SPARE, 16'($urandom_range(65535)));
        cfg_valid = 1'b0;
        settings_used++;
    endtask

    // mostly well-formed versions with random content, some damaged, some noise
    task automatic make_version();
        int parts[3];
        int r, pos;
        if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(5, 1)) str_buf.push_back(t_char'($urandom_range(255)));
            return;
        end
        if ($urandom_range(99) < 25)
            repeat ($urandom_range(3, 1)) str_buf.push_back(CH_SPACE);
        r = $urandom_range(99);
        if (r < 30) str_buf.push_back(CH_LOWER_V);
        else if (r < 40) str_buf.push_back(CH_UPPER_V);
        if ($urandom_range(99) < 15) begin
            for (int k = 0; k < 3; k++) parts[k] = exp_v[k];
        end else begin
            for (int k = 0; k < 3; k++) parts[k] = pick_part(k);
        end
        for (int k = 0; k < 3; k++) begin
            if (k > 0) str_buf.push_back(CH_DOT);
            if ($urandom_range(99) < 8) str_buf.push_back(CH_ZERO);
            put_text($sformatf("%0d", parts[k]));
        end
        if ($urandom_range(99) < 30)
            repeat ($urandom_range(3, 1)) str_buf.push_back(any_blank());
        if ($urandom_range(99) < 25) begin
            pos = $urandom_range(str_buf.size() - 1);
            case ($urandom_range(4))
                0: str_buf[pos] = t_char'($urandom_range(255, 1));
                1: str_buf.delete(pos);
                2: str_buf.push_back(t_char'($urandom_range(255, 1)));
                3: while (str_buf.size() > pos) void'(str_buf.pop_back());
                default: str_buf.insert(pos, $urandom_range(1) ? CH_DOT : any_blank());
            endcase
        end
        if ($urandom_range(99) < 15 || str_buf.size() == 0) begin
            str_buf.push_back(CH_NUL);
            repeat ($urandom_range(3)) str_buf.push_back(t_char'($urandom_range(255)));
        end
    endtask

    initial begin
        int stop_at;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        no_gaps       = 1'b0;
        stall_reqs    = 0;
        chars_sent    = 0;
        strings_sent  = 0;
        settings_used = 1;
        for (int k = 0; k < 3; k++) begin
            run_v[k] = 0;
            exp_v[k] = 0;
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: running and expected 0.0.0, trimming on
        send_text("0.0.0");
        send_text("65535.65535.65535");
        send_text("  v1.2.3");
        send_text("V0.0.1");
        send_text("65536.0.0");
        send_text("1.2.70000");
        send_text("1..3");
        send_text("v");
        send_text("1.2");
        send_text("1 2.3");
        send_text("1.2.3x");
        send_text("1.2.3.");
        put_text("1.2.3");
        str_buf.push_back(CH_SPACE);
        str_buf.push_back(CH_TAB);
        str_buf.push_back(CH_CR);
        str_buf.push_back(CH_LF);
        send_buf();
        put_text("1.2.3");
        str_buf.push_back(CH_TAB);
        put_text("x");
        send_buf();
        put_text("1.2.3");
        str_buf.push_back(CH_NUL);
        put_text("zz");
        send_buf();
        str_buf.push_back(CH_NUL);
        send_buf();
        send_text("   ");
        send_text("1. 2.3");
        send_text("vv1.2.3");
        send_text(" 007.08.09");

        // lowest settings, trimming off
        set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFE);
        send_text("1.2.3 ");

        for (int p = 0; p < 4; p++) begin
            if (p == 1) begin
                set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           16'($urandom_range(65535)) | 16'h0001);
                no_gaps = 1'b1;
            end else if (p > 1) begin
                set_config(any_reg_value(), any_reg_value(), any_reg_value(),
                           any_reg_value(), any_reg_value(), any_reg_value(),
                           16'($urandom_range(65535)));
                no_gaps = 1'b0;
            end
            stop_at = chars_sent + RANDOM_CHARS / 4;
            while (chars_sent < stop_at) begin
                make_version();
                send_buf();
            end
        end

        // output held off while single-character strings keep coming
        drain();
        no_gaps    = 1'b1;
        stall_reqs = stall_reqs + 1;
        repeat (60) begin
            str_buf.push_back(t_char'($urandom_range(255)));
            send_buf();
        end
        drain();
        no_gaps = 1'b0;

        $display("Covered %0d characters in %0d strings under %0d register settings,",
                 chars_sent, strings_sent, settings_used);
        $display("with a %0d-cycle output hold-off; %0d results checked, %0d well-formed.",
                 HOLD_CYCLES, checked, well_formed);
        if (fails == 0 && pending == 0) begin
            $display("version_string_parse_compare regression: pass");
        end else begin
            $display("%0d mismatches, %0d results outstanding", fails, pending);
            $display("version_string_parse_compare regression: fail");
        end
        $finish;
    end

endmodule
